// File: rtl/sads_pkg.sv
// ----------------------------------------------------------------------------
// sads_pkg: shared definitions for the shared-array double stack
// Operation codes, result status codes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package sads_pkg;

    // longest run of results that one show produces
    localparam int MaxResults = 16;
    localparam int RemW       = $clog2(MaxResults + 1);

    // operation selector carried in s_tuser
    typedef enum logic [2:0] {
        MODE_PUSH1  = 3'd0,
        MODE_PUSH2  = 3'd1,
        MODE_POP1   = 3'd2,
        MODE_POP2   = 3'd3,
        MODE_SHOW1  = 3'd4,
        MODE_SHOW2  = 3'd5,
        MODE_CLEAR  = 3'd6,
        MODE_UNUSED = 3'd7    // dropped without a result
    } mode_t;

    // result status carried in m_tuser
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE  = 4'd0,
        CMD_PUSH1 = 4'd1,
        CMD_PUSH2 = 4'd2,
        CMD_POP1  = 4'd3,
        CMD_POP2  = 4'd4,
        CMD_SHOW1 = 4'd5,
        CMD_SHOW2 = 4'd6,
        CMD_NEXT  = 4'd7,
        CMD_CLEAR = 4'd8,
        CMD_ERROR = 4'd9
    } op_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } state_t;

    typedef struct packed {
        op_t     op;
        status_t status;    // status reported by CMD_ERROR
    } cmd_t;

    typedef struct packed {
        logic first_empty;
        logic second_empty;
        logic full;
        logic last;         // result on the output is the final one
    } dp_status_t;

endpackage

// File: rtl/shared_array_double_stack_core.sv
// ----------------------------------------------------------------------------
// shared_array_double_stack_core: two LIFO stacks in one word memory
// Latency: a push, pop, clear or error result is valid the cycle after accept.
// Throughput: one item at a time; a show gives one word per cycle from the RAM
// registered read port while m_tready is high.
// Reset: asynchronous, clears both counts and the controller; the memory is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module shared_array_double_stack_core #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] data
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    sads_pkg::cmd_t       cmd;
    sads_pkg::dp_status_t stat;
    sads_pkg::status_t    status_out;

    sads_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .stat      (stat),
        .cmd       (cmd)
    );

    sads_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (s_tdata),
        .stat       (stat),
        .status_out (status_out),
        .data_out   (m_tdata),
        .last_out   (m_tlast)
    );

    assign m_tuser = status_out;

    // one item at a time: no input taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // error results are single, zero-data results
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != sads_pkg::ST_OK)) |-> (m_tlast && (m_tdata == 32'd0)))
        else $error("error result not final or carries data");

    // a show run continues without a gap after a non-final transfer
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && (m_tuser == sads_pkg::ST_OK)))
        else $error("show run broken");

    // the two stacks never hold more than the memory
    a_no_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.full && (cmd.op == sads_pkg::CMD_PUSH1 || cmd.op == sads_pkg::CMD_PUSH2))
        |-> 1'b0)
        else $error("push issued while memory is full");

endmodule

// File: rtl/sads_ram.sv
// ----------------------------------------------------------------------------
// sads_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module sads_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sads_datapath.sv
// ----------------------------------------------------------------------------
// sads_datapath: stack counts, word memory and result register
// Executes controller commands: pushes, pops, show walks and clear, and
// holds the status, data source and remaining-run count of the result.
// ----------------------------------------------------------------------------
module sads_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sads_pkg::cmd_t       cmd,
    input  logic [31:0]          value,
    output sads_pkg::dp_status_t stat,
    output sads_pkg::status_t    status_out,
    output logic [31:0]          data_out,
    output logic                 last_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [CW-1:0]             first_count_reg, first_count_next;
    logic [CW-1:0]             second_count_reg, second_count_next;
    logic [sads_pkg::RemW-1:0] rem_reg, rem_next;
    logic [AW-1:0]             addr_reg, addr_next;
    logic                      up_reg, up_next;
    sads_pkg::status_t         status_reg, status_next;
    logic                      data_sel_reg, data_sel_next;

    logic [CW:0]   count_sum;
    logic [CW-1:0] depth_c;
    logic [CW-1:0] first_top;    // first_count - 1
    logic [CW-1:0] second_top;   // DEPTH - second_count
    logic [CW-1:0] second_new;   // DEPTH - second_count - 1
    logic [CW-1:0] show_cnt;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    // address arithmetic and occupancy flags
    always_comb
    begin
        depth_c    = CW'(DEPTH);
        count_sum  = {1'b0, first_count_reg} + {1'b0, second_count_reg};
        first_top  = first_count_reg - CW'(1);
        second_top = depth_c - second_count_reg;
        second_new = second_top - CW'(1);
        show_cnt   = (cmd.op == sads_pkg::CMD_SHOW2) ? second_count_reg : first_count_reg;
    end

    assign stat.first_empty  = (first_count_reg == '0);
    assign stat.second_empty = (second_count_reg == '0);
    assign stat.full         = (count_sum >= (CW + 1)'(DEPTH));
    assign stat.last         = (rem_reg == sads_pkg::RemW'(1));

    // command decode
    always_comb
    begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        rem_next          = rem_reg;
        addr_next         = addr_reg;
        up_next           = up_reg;
        status_next       = status_reg;
        data_sel_next     = data_sel_reg;
        wr_en             = 1'b0;
        wr_addr           = first_count_reg[AW-1:0];
        rd_en             = 1'b0;
        rd_addr           = addr_reg;
        unique case (cmd.op)
            sads_pkg::CMD_PUSH1:
            begin
                wr_en            = 1'b1;
                wr_addr          = first_count_reg[AW-1:0];
                first_count_next = first_count_reg + CW'(1);
                status_next      = sads_pkg::ST_OK;
                data_sel_next    = 1'b0;
                rem_next         = sads_pkg::RemW'(1);
            end
            sads_pkg::CMD_PUSH2:
            begin
                wr_en             = 1'b1;
                wr_addr           = second_new[AW-1:0];
                second_count_next = second_count_reg + CW'(1);
                status_next       = sads_pkg::ST_OK;
                data_sel_next     = 1'b0;
                rem_next          = sads_pkg::RemW'(1);
            end
            sads_pkg::CMD_POP1:
            begin
                rd_en            = 1'b1;
                rd_addr          = first_top[AW-1:0];
                first_count_next = first_top;
                status_next      = sads_pkg::ST_OK;
                data_sel_next    = 1'b1;
                rem_next         = sads_pkg::RemW'(1);
            end
            sads_pkg::CMD_POP2:
            begin
                rd_en             = 1'b1;
                rd_addr           = second_top[AW-1:0];
                second_count_next = second_count_reg - CW'(1);
                status_next       = sads_pkg::ST_OK;
                data_sel_next     = 1'b1;
                rem_next          = sads_pkg::RemW'(1);
            end
            sads_pkg::CMD_SHOW1, sads_pkg::CMD_SHOW2:
            begin
                rd_en         = 1'b1;
                up_next       = (cmd.op == sads_pkg::CMD_SHOW2);
                rd_addr       = up_next ? second_top[AW-1:0] : first_top[AW-1:0];
                addr_next     = rd_addr;
                status_next   = sads_pkg::ST_OK;
                data_sel_next = 1'b1;
                // run is capped at the words nearest the top
                if (32'(show_cnt) > 32'(sads_pkg::MaxResults))
                begin
                    rem_next = sads_pkg::RemW'(sads_pkg::MaxResults);
                end
                else
                begin
                    rem_next = sads_pkg::RemW'(show_cnt);
                end
            end
            sads_pkg::CMD_NEXT:
            begin
                rd_en     = 1'b1;
                rd_addr   = up_reg ? (addr_reg + AW'(1)) : (addr_reg - AW'(1));
                addr_next = rd_addr;
                rem_next  = rem_reg - sads_pkg::RemW'(1);
            end
            sads_pkg::CMD_CLEAR:
            begin
                first_count_next  = '0;
                second_count_next = '0;
                status_next       = sads_pkg::ST_OK;
                data_sel_next     = 1'b0;
                rem_next          = sads_pkg::RemW'(1);
            end
            sads_pkg::CMD_ERROR:
            begin
                status_next   = cmd.status;
                data_sel_next = 1'b0;
                rem_next      = sads_pkg::RemW'(1);
            end
            sads_pkg::CMD_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            rem_reg          <= sads_pkg::RemW'(1);
            status_reg       <= sads_pkg::ST_OK;
            data_sel_reg     <= 1'b0;
        end
        else
        begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            rem_reg          <= rem_next;
            status_reg       <= status_next;
            data_sel_reg     <= data_sel_next;
        end
    end

    // walk address and direction
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        up_reg   <= up_next;
    end

    sads_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result fields
    assign status_out = status_reg;
    assign data_out   = data_sel_reg ? rd_data : 32'd0;
    assign last_out   = stat.last;

endmodule

// File: rtl/sads_ctrl.sv
// ----------------------------------------------------------------------------
// sads_ctrl: operation controller
// Accepts one item in idle, issues the matching datapath command and
// presents results until the final one of the run is transferred.
// ----------------------------------------------------------------------------
module sads_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [2:0]           in_mode,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  sads_pkg::dp_status_t stat,
    output sads_pkg::cmd_t       cmd
);

    sads_pkg::state_t state_reg, state_next;
    sads_pkg::mode_t  mode;

    assign mode = sads_pkg::mode_t'(in_mode);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sads_pkg::S_IDLE:
            begin
                // the unused code is dropped without a result
                if (in_valid && (mode != sads_pkg::MODE_UNUSED))
                begin
                    state_next = sads_pkg::S_EMIT;
                end
            end
            sads_pkg::S_EMIT:
            begin
                if (out_ready && stat.last)
                begin
                    state_next = sads_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sads_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.op     = sads_pkg::CMD_NONE;
        cmd.status = sads_pkg::ST_OK;
        unique case (state_reg)
            sads_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (mode)
                        sads_pkg::MODE_PUSH1, sads_pkg::MODE_PUSH2:
                        begin
                            if (stat.full)
                            begin
                                cmd.op     = sads_pkg::CMD_ERROR;
                                cmd.status = sads_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.op = (mode == sads_pkg::MODE_PUSH1) ?
                                         sads_pkg::CMD_PUSH1 : sads_pkg::CMD_PUSH2;
                            end
                        end
                        sads_pkg::MODE_POP1:
                        begin
                            cmd.op     = stat.first_empty ? sads_pkg::CMD_ERROR
                                                          : sads_pkg::CMD_POP1;
                            cmd.status = sads_pkg::ST_UNDERFLOW;
                        end
                        sads_pkg::MODE_POP2:
                        begin
                            cmd.op     = stat.second_empty ? sads_pkg::CMD_ERROR
                                                           : sads_pkg::CMD_POP2;
                            cmd.status = sads_pkg::ST_UNDERFLOW;
                        end
                        sads_pkg::MODE_SHOW1:
                        begin
                            cmd.op     = stat.first_empty ? sads_pkg::CMD_ERROR
                                                          : sads_pkg::CMD_SHOW1;
                            cmd.status = sads_pkg::ST_EMPTY;
                        end
                        sads_pkg::MODE_SHOW2:
                        begin
                            cmd.op     = stat.second_empty ? sads_pkg::CMD_ERROR
                                                           : sads_pkg::CMD_SHOW2;
                            cmd.status = sads_pkg::ST_EMPTY;
                        end
                        sads_pkg::MODE_CLEAR:
                        begin
                            cmd.op = sads_pkg::CMD_CLEAR;
                        end
                        default:
                        begin
                            cmd.op = sads_pkg::CMD_NONE;
                        end
                    endcase
                end
            end
            sads_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
                // fetch the next word of a show run as this one transfers
                if (out_ready && !stat.last)
                begin
                    cmd.op = sads_pkg::CMD_NEXT;
                end
            end
            default:
            begin
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sads_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
